### hdl/tbd_pkg.sv
// Shared types and constants for the tape block deframer.
package tbd_pkg;

    localparam int BLOCK_LIMIT_DEF = 256;
    localparam int MAX_FILES_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0]  FLAG_HEADER     = 8'h00;
    localparam logic [7:0]  FLAG_DATA       = 8'hFF;
    localparam logic [7:0]  TYPE_PROGRAM    = 8'd0;
    localparam logic [7:0]  TYPE_CODE       = 8'd3;
    localparam logic [15:0] PROG_START_ADDR = 16'h5CCB;
    localparam logic [15:0] HEADER_MIN      = 16'd17;
    localparam logic [15:0] LEN_OVERHEAD    = 16'd2;

    localparam logic KIND_BLOCK   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] OUT_SINGLE  = 2'd0;
    localparam logic [1:0] OUT_ARCHIVE = 2'd1;
    localparam logic [1:0] OUT_NONE    = 2'd2;
    localparam logic [1:0] OUT_SHORT   = 2'd3;

    // One queue entry: what a single accepted byte asks the back end to emit.
    typedef struct packed {
        logic        has_block;
        logic        has_summary;
        logic [7:0]  flag;
        logic [15:0] payload_len;
        logic        checksum_ok;
        logic        header_valid;
        logic [7:0]  header_type;
        logic        loadable;
        logic [15:0] start_address;
        logic [15:0] end_address;
        logic [1:0]  outcome;
    } tbd_entry_t;

endpackage

### hdl/tbd_front.sv
// Front end: byte acceptance, block deframing and header/data pairing.
module tbd_front #(
    parameter int BLOCK_LIMIT = tbd_pkg::BLOCK_LIMIT_DEF,
    parameter int MAX_FILES   = tbd_pkg::MAX_FILES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_data_byte,
    input  logic                             s_last_byte,
    input  logic                             q_full,
    output logic                             q_push,
    output tbd_pkg::tbd_entry_t              q_entry,
    output logic [$clog2(MAX_FILES+1)-1:0]   q_count
);

    localparam int FILE_W  = $clog2(MAX_FILES + 1);
    localparam int BLOCK_W = $clog2(BLOCK_LIMIT + 1);

    typedef enum logic [1:0] {PH_LEN_LO, PH_LEN_HI, PH_BODY} phase_t;

    phase_t              phase_reg;
    logic [15:0]         len_reg;
    logic [15:0]         pos_reg;
    logic [7:0]          xor_reg;
    logic [7:0]          flag_reg;
    logic [7:0]          type_reg;
    logic [15:0]         param_reg;
    logic                prior_hv_reg;
    logic [7:0]          prior_type_reg;
    logic [15:0]         prior_param_reg;
    logic [BLOCK_W-1:0]  blocks_reg;
    logic [FILE_W-1:0]   files_reg;
    logic                stopped_reg;

    logic                accept;
    logic [7:0]          flag_next;
    logic [7:0]          type_next;
    logic [15:0]         param_next;
    logic [7:0]          xor_next;
    logic [15:0]         len_next;
    logic                block_done;
    logic [15:0]         psize;
    logic                hv;
    logic                loadable;
    logic [15:0]         start_addr;
    logic [FILE_W-1:0]   files_next;
    logic [BLOCK_W-1:0]  blocks_next;
    logic [1:0]          outcome;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        flag_next  = flag_reg;
        type_next  = type_reg;
        param_next = param_reg;
        if (pos_reg == 16'd0) begin
            flag_next = s_data_byte;
        end else if (pos_reg == 16'd1) begin
            type_next = s_data_byte;
        end else if (pos_reg == 16'd14) begin
            param_next = {param_reg[15:8], s_data_byte};
        end else if (pos_reg == 16'd15) begin
            param_next = {s_data_byte, param_reg[7:0]};
        end
        xor_next = xor_reg ^ s_data_byte;
        len_next = {s_data_byte, len_reg[7:0]};

        block_done = !stopped_reg && (phase_reg == PH_BODY)
                     && (({1'b0, pos_reg} + 17'd1) >= {1'b0, len_reg});
        psize = (len_reg >= tbd_pkg::LEN_OVERHEAD) ? len_reg - tbd_pkg::LEN_OVERHEAD : 16'd0;
        hv    = (flag_next == tbd_pkg::FLAG_HEADER) && (psize >= tbd_pkg::HEADER_MIN);

        loadable = block_done && prior_hv_reg && (flag_next == tbd_pkg::FLAG_DATA)
                   && ((prior_type_reg == tbd_pkg::TYPE_CODE)
                       || (prior_type_reg == tbd_pkg::TYPE_PROGRAM))
                   && (psize != 16'd0) && (files_reg < FILE_W'(MAX_FILES));
        if (!loadable) begin
            start_addr = 16'd0;
        end else if (prior_type_reg == tbd_pkg::TYPE_CODE) begin
            start_addr = prior_param_reg;
        end else begin
            start_addr = tbd_pkg::PROG_START_ADDR;
        end

        files_next  = files_reg + FILE_W'(loadable);
        blocks_next = blocks_reg + BLOCK_W'(block_done);

        if (blocks_next < BLOCK_W'(2)) begin
            outcome = tbd_pkg::OUT_SHORT;
        end else if (files_next == '0) begin
            outcome = tbd_pkg::OUT_NONE;
        end else if (files_next == FILE_W'(1)) begin
            outcome = tbd_pkg::OUT_SINGLE;
        end else begin
            outcome = tbd_pkg::OUT_ARCHIVE;
        end
    end

    assign q_push                = accept && (block_done || s_last_byte);
    assign q_count               = files_next;
    assign q_entry.has_block     = block_done;
    assign q_entry.has_summary   = s_last_byte;
    assign q_entry.flag          = flag_next;
    assign q_entry.payload_len   = psize;
    assign q_entry.checksum_ok   = (xor_next == 8'd0);
    assign q_entry.header_valid  = hv;
    assign q_entry.header_type   = hv ? type_next : 8'd0;
    assign q_entry.loadable      = loadable;
    assign q_entry.start_address = start_addr;
    assign q_entry.end_address   = loadable ? start_addr + psize : 16'd0;
    assign q_entry.outcome       = outcome;

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_last_byte)) begin
            // the last byte of an image returns everything to the start state
            phase_reg       <= PH_LEN_LO;
            stopped_reg     <= 1'b0;
            prior_hv_reg    <= 1'b0;
            prior_type_reg  <= 8'd0;
            prior_param_reg <= 16'd0;
            blocks_reg      <= '0;
            files_reg       <= '0;
            len_reg         <= 16'd0;
            pos_reg         <= 16'd0;
            xor_reg         <= 8'd0;
            flag_reg        <= 8'd0;
            type_reg        <= 8'd0;
            param_reg       <= 16'd0;
        end else if (accept && !stopped_reg) begin
            case (phase_reg)
                PH_LEN_LO: begin
                    len_reg   <= {8'd0, s_data_byte};
                    phase_reg <= PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    len_reg <= len_next;
                    if (len_next == 16'd0) begin
                        stopped_reg <= 1'b1;
                        phase_reg   <= PH_LEN_LO;
                    end else begin
                        phase_reg <= PH_BODY;
                        pos_reg   <= 16'd0;
                        xor_reg   <= 8'd0;
                        flag_reg  <= 8'd0;
                        type_reg  <= 8'd0;
                        param_reg <= 16'd0;
                    end
                end
                PH_BODY: begin
                    xor_reg   <= xor_next;
                    flag_reg  <= flag_next;
                    type_reg  <= type_next;
                    param_reg <= param_next;
                    if (block_done) begin
                        prior_hv_reg    <= hv;
                        prior_type_reg  <= type_next;
                        prior_param_reg <= param_next;
                        files_reg       <= files_next;
                        blocks_reg      <= blocks_next;
                        if (blocks_next >= BLOCK_W'(BLOCK_LIMIT)) begin
                            stopped_reg <= 1'b1;
                        end
                        phase_reg <= PH_LEN_LO;
                    end else begin
                        pos_reg <= pos_reg + 16'd1;
                    end
                end
                default: begin
                    phase_reg <= PH_LEN_LO;
                end
            endcase
        end
    end

endmodule

### hdl/tbd_queue.sv
// Short queue of requests between the front end and the result stage.
module tbd_queue #(
    parameter int DEPTH = tbd_pkg::QUEUE_DEPTH_DEF,
    parameter int CNT_W = $clog2(tbd_pkg::MAX_FILES_DEF + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  tbd_pkg::tbd_entry_t   push_entry,
    input  logic [CNT_W-1:0]      push_count,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output tbd_pkg::tbd_entry_t   head_entry,
    output logic [CNT_W-1:0]      head_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);

    tbd_pkg::tbd_entry_t entry_mem [DEPTH];
    logic [CNT_W-1:0]    count_mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [OCC_W-1:0]    occ_reg;
    logic                do_push;
    logic                do_pop;

    assign full       = (occ_reg == OCC_W'(DEPTH));
    assign empty      = (occ_reg == '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;
    assign head_entry = entry_mem[rd_ptr_reg];
    assign head_count = count_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_mem[wr_ptr_reg] <= push_entry;
            count_mem[wr_ptr_reg] <= push_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                occ_reg <= occ_reg + OCC_W'(1);
            end else if (do_pop && !do_push) begin
                occ_reg <= occ_reg - OCC_W'(1);
            end
        end
    end

endmodule

### hdl/tbd_back.sv
// Result stage: expands queued requests into block and summary records.
module tbd_back #(
    parameter int CNT_W = $clog2(tbd_pkg::MAX_FILES_DEF + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  tbd_pkg::tbd_entry_t  q_entry,
    input  logic [CNT_W-1:0]     q_count,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_record_kind,
    output logic [7:0]           m_block_flag,
    output logic [15:0]          m_payload_len,
    output logic                 m_checksum_ok,
    output logic                 m_header_valid,
    output logic [7:0]           m_header_type,
    output logic                 m_loadable,
    output logic [15:0]          m_start_address,
    output logic [15:0]          m_end_address,
    output logic [CNT_W-1:0]     m_file_count,
    output logic [1:0]           m_outcome,
    output logic                 m_last
);

    logic             valid_reg;
    logic             sum_pend_reg;
    logic [CNT_W-1:0] sum_count_reg;
    logic [1:0]       sum_outcome_reg;
    logic             load;

    assign load    = !valid_reg || m_ready;
    assign q_pop   = load && !sum_pend_reg && !q_empty;
    assign m_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            sum_pend_reg <= 1'b0;
        end else if (load) begin
            if (sum_pend_reg) begin
                valid_reg    <= 1'b1;
                sum_pend_reg <= 1'b0;
            end else if (!q_empty) begin
                valid_reg    <= 1'b1;
                // a block closed by the last byte is followed by the summary
                sum_pend_reg <= q_entry.has_block && q_entry.has_summary;
            end else begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (sum_pend_reg || (!q_empty && !q_entry.has_block)) begin
                m_record_kind   <= tbd_pkg::KIND_SUMMARY;
                m_block_flag    <= 8'd0;
                m_payload_len   <= 16'd0;
                m_checksum_ok   <= 1'b0;
                m_header_valid  <= 1'b0;
                m_header_type   <= 8'd0;
                m_loadable      <= 1'b0;
                m_start_address <= 16'd0;
                m_end_address   <= 16'd0;
                m_file_count    <= sum_pend_reg ? sum_count_reg : q_count;
                m_outcome       <= sum_pend_reg ? sum_outcome_reg : q_entry.outcome;
                m_last          <= 1'b1;
            end else if (!q_empty) begin
                m_record_kind   <= tbd_pkg::KIND_BLOCK;
                m_block_flag    <= q_entry.flag;
                m_payload_len   <= q_entry.payload_len;
                m_checksum_ok   <= q_entry.checksum_ok;
                m_header_valid  <= q_entry.header_valid;
                m_header_type   <= q_entry.header_type;
                m_loadable      <= q_entry.loadable;
                m_start_address <= q_entry.start_address;
                m_end_address   <= q_entry.end_address;
                m_file_count    <= q_count;
                m_outcome       <= tbd_pkg::OUT_SINGLE;
                m_last          <= !q_entry.has_summary;
                sum_count_reg   <= q_count;
                sum_outcome_reg <= q_entry.outcome;
            end
        end
    end

endmodule

### hdl/tape_block_deframer.sv
// Tape block deframer: takes one image byte per cycle while the queue has room, and
// emits a record per completed block, plus a summary record on the byte marked last.
// Every cycle a byte can be accepted while the queue between the deframing front end
// and the result register has room; a last byte that also closes a block yields two
// records, which the result stage delivers one after the other. A byte's request is
// written into the queue and from there loaded into the result register.
module tape_block_deframer #(
    parameter int BLOCK_LIMIT = tbd_pkg::BLOCK_LIMIT_DEF,
    parameter int MAX_FILES   = tbd_pkg::MAX_FILES_DEF,
    parameter int QUEUE_DEPTH = tbd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_data_byte,
    input  logic                            s_last_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_record_kind,
    output logic [7:0]                      m_block_flag,
    output logic [15:0]                     m_payload_len,
    output logic                            m_checksum_ok,
    output logic                            m_header_valid,
    output logic [7:0]                      m_header_type,
    output logic                            m_loadable,
    output logic [15:0]                     m_start_address,
    output logic [15:0]                     m_end_address,
    output logic [$clog2(MAX_FILES+1)-1:0]  m_file_count,
    output logic [1:0]                      m_outcome,
    output logic                            m_last
);

    localparam int CNT_W = $clog2(MAX_FILES + 1);

    logic                 q_full;
    logic                 q_push;
    logic                 q_empty;
    logic                 q_pop;
    tbd_pkg::tbd_entry_t  push_entry;
    tbd_pkg::tbd_entry_t  head_entry;
    logic [CNT_W-1:0]     push_count;
    logic [CNT_W-1:0]     head_count;

    tbd_front #(
        .BLOCK_LIMIT (BLOCK_LIMIT),
        .MAX_FILES   (MAX_FILES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry),
        .q_count     (push_count)
    );

    tbd_queue #(
        .DEPTH (QUEUE_DEPTH),
        .CNT_W (CNT_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .push_count (push_count),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head_entry (head_entry),
        .head_count (head_count)
    );

    tbd_back #(
        .CNT_W (CNT_W)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_entry         (head_entry),
        .q_count         (head_count),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_record_kind   (m_record_kind),
        .m_block_flag    (m_block_flag),
        .m_payload_len   (m_payload_len),
        .m_checksum_ok   (m_checksum_ok),
        .m_header_valid  (m_header_valid),
        .m_header_type   (m_header_type),
        .m_loadable      (m_loadable),
        .m_start_address (m_start_address),
        .m_end_address   (m_end_address),
        .m_file_count    (m_file_count),
        .m_outcome       (m_outcome),
        .m_last          (m_last)
    );

endmodule
